// File: rtl/core/point_density_image_accumulator_assert.svh
// assertion macros for the point density image accumulator checker
`ifndef POINT_DENSITY_IMAGE_ACCUMULATOR_ASSERT_SVH
`define POINT_DENSITY_IMAGE_ACCUMULATOR_ASSERT_SVH

// same-cycle implication
`define PDIA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PDIA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/pdia_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdia_pkg
// shared types and constants of the point density image accumulator
// ----------------------------------------------------------------------------
package pdia_pkg;

    localparam int COORD_W         = 32;
    localparam int CPP_W           = 16;
    localparam int INT_W           = 8;
    localparam int Q_W             = 16;
    localparam int HIST_W          = 19;
    localparam int HIST_DEPTH      = 256;
    localparam int HIST_AW         = 8;
    localparam int CUM_W           = 27;
    localparam int PROD_W          = CUM_W + Q_W;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 16;
    localparam int MODE_W          = 2;
    localparam int GRID_WIDTH_DEF  = 512;
    localparam int GRID_HEIGHT_DEF = 512;

    localparam logic [CPP_W-1:0] CPP_RESET   = 16'd1;
    localparam logic [INT_W-1:0] STEP_RESET  = 8'd1;
    localparam logic [INT_W-1:0] MAX_RESET   = 8'd255;
    localparam logic [Q_W-1:0]   Q_RESET     = 16'd64881;
    localparam logic [INT_W-1:0] THR_RESET   = 8'd255;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CPP      = 3'd0,
        REG_STEP     = 3'd1,
        REG_MAX      = 3'd2,
        REG_AUTO     = 3'd3,
        REG_QUANTILE = 3'd4
    } cfg_reg_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_ADD    = 2'd0,
        MODE_THRESH = 2'd1,
        MODE_READ   = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_ADD_RD,
        ST_ADD_WR,
        ST_HIST,
        ST_THR,
        ST_RD_RD,
        ST_RD_DAT,
        ST_SDIV,
        ST_FIN
    } top_state_t;

    typedef enum logic [3:0] {
        H_IDLE,
        H_DEC_RD,
        H_DEC_WR,
        H_INC_RD,
        H_INC_WR,
        H_SUM_RD,
        H_SUM_ACC,
        H_MUL,
        H_WALK_RD,
        H_WALK_ACC
    } hist_state_t;

    typedef struct packed {
        logic                clr_we;
        logic [HIST_AW-1:0]  clr_addr;
        logic                upd;
        logic                dec_en;
        logic [INT_W-1:0]    dec_idx;
        logic [INT_W-1:0]    inc_idx;
        logic                thr;
    } hist_cmd_t;

endpackage

// File: rtl/core/pdia_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdia_div
// unsigned restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module pdia_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [pdia_pkg::COORD_W-1:0] numer,
    input  logic [pdia_pkg::CPP_W-1:0]   denom,
    output logic                         done,
    output logic [pdia_pkg::COORD_W-1:0] quot
);

    localparam int NW = pdia_pkg::COORD_W;
    localparam int DW = pdia_pkg::CPP_W;
    localparam int CW = $clog2(NW);

    logic            busy_reg, busy_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [NW-1:0]   quo_reg, quo_next;
    logic [DW-1:0]   rem_reg, rem_next;
    logic [DW-1:0]   den_reg, den_next;
    logic [DW:0]     trial;
    logic [DW:0]     diff;

    assign trial = {rem_reg, quo_reg[NW-1]};
    assign diff  = trial - {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        done      = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = numer;
            rem_next  = '0;
            den_next  = denom;
        end
        else if (busy_reg)
        begin
            if (!diff[DW])
            begin
                rem_next = diff[DW-1:0];
                quo_next = {quo_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DW-1:0];
                quo_next = {quo_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(NW - 1))
            begin
                busy_next = 1'b0;
                done      = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign quot = quo_next;

endmodule

// File: rtl/core/pdia_hist.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdia_hist
// intensity histogram memory with update and quantile threshold walk
// ----------------------------------------------------------------------------
module pdia_hist (
    input  logic                       clk,
    input  logic                       rst_n,
    input  pdia_pkg::hist_cmd_t        cmd,
    input  logic [pdia_pkg::INT_W-1:0] eff_max,
    input  logic [pdia_pkg::Q_W-1:0]   quantile,
    output logic                       done,
    output logic [pdia_pkg::INT_W-1:0] threshold
);

    localparam int HW = pdia_pkg::HIST_W;
    localparam int AW = pdia_pkg::HIST_AW;
    localparam int IW = pdia_pkg::INT_W;
    localparam int CW = pdia_pkg::CUM_W;
    localparam int PW = pdia_pkg::PROD_W;
    localparam int QW = pdia_pkg::Q_W;

    pdia_pkg::hist_state_t state_reg, state_next;

    logic [HW-1:0] hist_mem [pdia_pkg::HIST_DEPTH];
    logic [HW-1:0] rdata_reg;

    logic [IW-1:0] dec_idx_reg, dec_idx_next;
    logic [IW-1:0] inc_idx_reg, inc_idx_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [CW-1:0] cum_reg, cum_next;
    logic [PW-1:0] prod_reg, prod_next;
    logic [IW-1:0] work_reg, work_next;
    logic [IW-1:0] thr_reg, thr_next;

    logic          re;
    logic [AW-1:0] raddr;
    logic          we;
    logic [AW-1:0] waddr;
    logic [HW-1:0] wdata;
    logic          pass;

    assign pass = {cum_reg, {QW{1'b0}}} > prod_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pdia_pkg::H_IDLE:
            begin
                if (cmd.upd)
                    state_next = cmd.dec_en ? pdia_pkg::H_DEC_RD : pdia_pkg::H_INC_RD;
                else if (cmd.thr)
                    state_next = pdia_pkg::H_SUM_RD;
            end
            pdia_pkg::H_DEC_RD:  state_next = pdia_pkg::H_DEC_WR;
            pdia_pkg::H_DEC_WR:  state_next = pdia_pkg::H_INC_RD;
            pdia_pkg::H_INC_RD:  state_next = pdia_pkg::H_INC_WR;
            pdia_pkg::H_INC_WR:  state_next = pdia_pkg::H_IDLE;
            pdia_pkg::H_SUM_RD:  state_next = pdia_pkg::H_SUM_ACC;
            pdia_pkg::H_SUM_ACC:
                state_next = (idx_reg == eff_max) ? pdia_pkg::H_MUL : pdia_pkg::H_SUM_RD;
            pdia_pkg::H_MUL:     state_next = pdia_pkg::H_WALK_RD;
            pdia_pkg::H_WALK_RD:
                state_next = pass ? pdia_pkg::H_WALK_ACC : pdia_pkg::H_IDLE;
            pdia_pkg::H_WALK_ACC:
                state_next = (idx_reg == IW'(1)) ? pdia_pkg::H_IDLE : pdia_pkg::H_WALK_RD;
            default:             state_next = pdia_pkg::H_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        re           = 1'b0;
        raddr        = '0;
        we           = 1'b0;
        waddr        = '0;
        wdata        = '0;
        done         = 1'b0;
        dec_idx_next = dec_idx_reg;
        inc_idx_next = inc_idx_reg;
        idx_next     = idx_reg;
        cum_next     = cum_reg;
        prod_next    = prod_reg;
        work_next    = work_reg;
        thr_next     = thr_reg;
        case (state_reg)
            pdia_pkg::H_IDLE:
            begin
                if (cmd.clr_we)
                begin
                    we    = 1'b1;
                    waddr = cmd.clr_addr;
                end
                if (cmd.upd)
                begin
                    dec_idx_next = cmd.dec_idx;
                    inc_idx_next = cmd.inc_idx;
                end
                else if (cmd.thr)
                begin
                    idx_next = IW'(1);
                    cum_next = '0;
                end
            end
            pdia_pkg::H_DEC_RD:
            begin
                re    = 1'b1;
                raddr = dec_idx_reg;
            end
            pdia_pkg::H_DEC_WR:
            begin
                we    = 1'b1;
                waddr = dec_idx_reg;
                wdata = rdata_reg - 1'b1;
            end
            pdia_pkg::H_INC_RD:
            begin
                re    = 1'b1;
                raddr = inc_idx_reg;
            end
            pdia_pkg::H_INC_WR:
            begin
                we    = 1'b1;
                waddr = inc_idx_reg;
                wdata = rdata_reg + 1'b1;
                done  = 1'b1;
            end
            pdia_pkg::H_SUM_RD:
            begin
                re    = 1'b1;
                raddr = idx_reg;
            end
            pdia_pkg::H_SUM_ACC:
            begin
                cum_next = cum_reg + CW'(rdata_reg);
                if (idx_reg != eff_max)
                    idx_next = idx_reg + 1'b1;
            end
            pdia_pkg::H_MUL:
            begin
                prod_next = PW'(quantile) * PW'(cum_reg);
                idx_next  = eff_max;
                work_next = eff_max;
            end
            pdia_pkg::H_WALK_RD:
            begin
                if (pass)
                begin
                    re        = 1'b1;
                    raddr     = idx_reg;
                    work_next = idx_reg;
                end
                else
                begin
                    done     = 1'b1;
                    thr_next = work_reg;
                end
            end
            pdia_pkg::H_WALK_ACC:
            begin
                cum_next = cum_reg - CW'(rdata_reg);
                if (idx_reg == IW'(1))
                begin
                    done     = 1'b1;
                    thr_next = work_reg;
                end
                else
                    idx_next = idx_reg - 1'b1;
            end
            default:
            begin
                re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pdia_pkg::H_IDLE;
            thr_reg   <= pdia_pkg::THR_RESET;
        end
        else
        begin
            state_reg <= state_next;
            thr_reg   <= thr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dec_idx_reg <= dec_idx_next;
        inc_idx_reg <= inc_idx_next;
        idx_reg     <= idx_next;
        cum_reg     <= cum_next;
        prod_reg    <= prod_next;
        work_reg    <= work_next;
    end

    // histogram memory
    always_ff @(posedge clk)
    begin
        if (we)
            hist_mem[waddr] <= wdata;
        if (re)
            rdata_reg <= hist_mem[raddr];
    end

    assign threshold = thr_reg;

endmodule

// File: rtl/core/point_density_image_accumulator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_density_image_accumulator
// point density image with intensity histogram and quantile contrast stretch
// ----------------------------------------------------------------------------
// After reset the block sweeps the pixel and histogram memories to zero, one
// entry a cycle, and takes no transaction until then; configuration writes
// are taken throughout. One item is handled at a time. An add point is taken,
// runs the bit-serial coordinate dividers, then the pixel read-modify-write,
// the histogram update (without the decrement when the pixel was zero) and
// the load of the result; a point dropped out of range or with a zero step
// goes from the dividers straight to the result. A threshold command walks
// the histogram memory one read at a time, up to the intensity ceiling eff_max.
// A stretched read reuses the x divider. The result sits in an output
// register, so the next item is taken while it waits.
module point_density_image_accumulator #(
    parameter int GRID_WIDTH  = pdia_pkg::GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = pdia_pkg::GRID_HEIGHT_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [pdia_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pdia_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [pdia_pkg::MODE_W-1:0]       mode,
    input  logic signed [pdia_pkg::COORD_W-1:0] x_coord,
    input  logic signed [pdia_pkg::COORD_W-1:0] y_coord,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              status,
    output logic [pdia_pkg::INT_W-1:0]        pixel_value,
    output logic [pdia_pkg::INT_W-1:0]        threshold
);

    localparam int DEPTH   = GRID_WIDTH * GRID_HEIGHT;
    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int XW      = (GRID_WIDTH > 1) ? $clog2(GRID_WIDTH) : 1;
    localparam int YW      = (GRID_HEIGHT > 1) ? $clog2(GRID_HEIGHT) : 1;
    localparam int CLR_LEN = (DEPTH > pdia_pkg::HIST_DEPTH) ? DEPTH : pdia_pkg::HIST_DEPTH;
    localparam int NW      = $clog2(CLR_LEN + 1);
    localparam int CW      = pdia_pkg::COORD_W;
    localparam int IW      = pdia_pkg::INT_W;
    localparam int QW      = pdia_pkg::CPP_W;

    // configuration
    logic [pdia_pkg::CPP_W-1:0] cpp_reg;
    logic [IW-1:0]              step_reg;
    logic [IW-1:0]              max_reg;
    logic                       auto_reg;
    logic [pdia_pkg::Q_W-1:0]   q_reg;
    logic [pdia_pkg::CPP_W-1:0] eff_cpp;
    logic [IW-1:0]              eff_max;
    logic [IW-1:0]              eff_thr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cpp_reg  <= pdia_pkg::CPP_RESET;
            step_reg <= pdia_pkg::STEP_RESET;
            max_reg  <= pdia_pkg::MAX_RESET;
            auto_reg <= 1'b0;
            q_reg    <= pdia_pkg::Q_RESET;
        end
        else if (cfg_we)
        begin
            case (pdia_pkg::cfg_reg_t'(cfg_index))
                pdia_pkg::REG_CPP:      cpp_reg  <= cfg_data;
                pdia_pkg::REG_STEP:     step_reg <= cfg_data[IW-1:0];
                pdia_pkg::REG_MAX:      max_reg  <= cfg_data[IW-1:0];
                pdia_pkg::REG_AUTO:     auto_reg <= cfg_data[0];
                pdia_pkg::REG_QUANTILE: q_reg    <= cfg_data;
                default:                ;
            endcase
        end
    end

    assign eff_cpp = (cpp_reg == '0) ? pdia_pkg::CPP_W'(1) : cpp_reg;
    assign eff_max = (max_reg == '0) ? IW'(1) : max_reg;

    pdia_pkg::top_state_t state_reg, state_next;

    logic                 accept;
    logic [NW-1:0]        clr_cnt_reg, clr_cnt_next;
    logic [CW-1:0]        x_reg, x_next;
    logic [CW-1:0]        y_reg, y_next;
    logic [AW-1:0]        addr_reg, addr_next;
    logic                 res_status_reg, res_status_next;
    logic [IW-1:0]        res_pix_reg, res_pix_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_status_reg, out_status_next;
    logic [IW-1:0]        out_pix_reg, out_pix_next;
    logic [IW-1:0]        out_thr_reg, out_thr_next;

    // pixel memory
    logic [IW-1:0]        pix_mem [DEPTH];
    logic [IW-1:0]        pix_rdata_reg;
    logic                 pix_re;
    logic                 pix_we;
    logic [AW-1:0]        pix_waddr;
    logic [IW-1:0]        pix_wdata;

    // divider and histogram
    logic                 div_start_x;
    logic                 div_start_y;
    logic [CW-1:0]        num_x;
    logic [QW-1:0]        den_x;
    logic [CW-1:0]        abs_x;
    logic [CW-1:0]        abs_y;
    logic                 div_done_x;
    logic                 div_done_y;
    logic [CW-1:0]        quo_x;
    logic [CW-1:0]        quo_y;
    pdia_pkg::hist_cmd_t  hcmd;
    logic                 hist_done;
    logic [IW-1:0]        hist_thr;

    logic [XW-1:0]        col_sel;
    logic [YW-1:0]        row_sel;
    logic [AW-1:0]        addr_calc;
    logic                 rd_in_grid;
    logic                 x_ok;
    logic                 y_ok;
    logic                 res_free;
    logic [IW:0]          sum9;
    logic [IW-1:0]        nv;
    logic [2*IW-1:0]      stretch_num;
    logic                 clr_last;

    assign accept   = in_valid && in_ready;
    assign abs_x    = x_coord[CW-1] ? (~x_coord + 1'b1) : x_coord;
    assign abs_y    = y_coord[CW-1] ? (~y_coord + 1'b1) : y_coord;
    assign eff_thr  = (hist_thr == '0) ? IW'(1) : hist_thr;
    assign res_free = !out_valid_reg || out_ready;
    assign clr_last = (clr_cnt_reg == NW'(CLR_LEN - 1));

    assign rd_in_grid = !x_coord[CW-1] && (x_coord < CW'(GRID_WIDTH))
                     && !y_coord[CW-1] && (y_coord < CW'(GRID_HEIGHT));
    assign x_ok = (quo_x == '0) || (!x_reg[CW-1] && (quo_x < CW'(GRID_WIDTH)));
    assign y_ok = (quo_y == '0) || (!y_reg[CW-1] && (quo_y < CW'(GRID_HEIGHT)));

    assign col_sel   = (state_reg == pdia_pkg::ST_IDLE) ? x_coord[XW-1:0] : quo_x[XW-1:0];
    assign row_sel   = (state_reg == pdia_pkg::ST_IDLE) ? y_coord[YW-1:0] : quo_y[YW-1:0];
    assign addr_calc = AW'(AW'(row_sel) * AW'(GRID_WIDTH) + AW'(col_sel));

    assign sum9        = {1'b0, pix_rdata_reg} + {1'b0, step_reg};
    assign nv          = (sum9 > {1'b0, eff_max}) ? eff_max : sum9[IW-1:0];
    assign stretch_num = pix_rdata_reg * eff_max;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pdia_pkg::ST_CLEAR:
                if (clr_last)
                    state_next = pdia_pkg::ST_IDLE;
            pdia_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (pdia_pkg::mode_t'(mode))
                        pdia_pkg::MODE_ADD:    state_next = pdia_pkg::ST_DIV;
                        pdia_pkg::MODE_THRESH: state_next = pdia_pkg::ST_THR;
                        pdia_pkg::MODE_READ:
                            state_next = rd_in_grid ? pdia_pkg::ST_RD_RD : pdia_pkg::ST_FIN;
                        default:               state_next = pdia_pkg::ST_FIN;
                    endcase
                end
            end
            pdia_pkg::ST_DIV:
                if (div_done_x && div_done_y)
                    state_next = (x_ok && y_ok && step_reg != '0) ?
                                 pdia_pkg::ST_ADD_RD : pdia_pkg::ST_FIN;
            pdia_pkg::ST_ADD_RD: state_next = pdia_pkg::ST_ADD_WR;
            pdia_pkg::ST_ADD_WR: state_next = pdia_pkg::ST_HIST;
            pdia_pkg::ST_HIST:
                if (hist_done)
                    state_next = pdia_pkg::ST_FIN;
            pdia_pkg::ST_THR:
                if (hist_done)
                    state_next = pdia_pkg::ST_FIN;
            pdia_pkg::ST_RD_RD:  state_next = pdia_pkg::ST_RD_DAT;
            pdia_pkg::ST_RD_DAT:
                state_next = (auto_reg && pix_rdata_reg != '0 && pix_rdata_reg <= eff_thr) ?
                             pdia_pkg::ST_SDIV : pdia_pkg::ST_FIN;
            pdia_pkg::ST_SDIV:
                if (div_done_x)
                    state_next = pdia_pkg::ST_FIN;
            pdia_pkg::ST_FIN:
                if (res_free)
                    state_next = pdia_pkg::ST_IDLE;
            default:             state_next = pdia_pkg::ST_IDLE;
        endcase
    end

    // outputs of the controller
    always_comb
    begin
        in_ready      = 1'b0;
        div_start_x   = 1'b0;
        div_start_y   = 1'b0;
        num_x         = abs_x;
        den_x         = eff_cpp;
        pix_re        = 1'b0;
        pix_we        = 1'b0;
        pix_waddr     = addr_reg;
        pix_wdata     = nv;
        hcmd          = '0;
        case (state_reg)
            pdia_pkg::ST_CLEAR:
            begin
                pix_we        = (clr_cnt_reg < NW'(DEPTH));
                pix_waddr     = clr_cnt_reg[AW-1:0];
                pix_wdata     = '0;
                hcmd.clr_we   = (clr_cnt_reg < NW'(pdia_pkg::HIST_DEPTH));
                hcmd.clr_addr = clr_cnt_reg[pdia_pkg::HIST_AW-1:0];
            end
            pdia_pkg::ST_IDLE:
            begin
                in_ready    = 1'b1;
                div_start_x = accept && (mode == pdia_pkg::MODE_ADD);
                div_start_y = accept && (mode == pdia_pkg::MODE_ADD);
                hcmd.thr    = accept && (mode == pdia_pkg::MODE_THRESH);
            end
            pdia_pkg::ST_ADD_RD,
            pdia_pkg::ST_RD_RD:
                pix_re = 1'b1;
            pdia_pkg::ST_ADD_WR:
            begin
                pix_we       = 1'b1;
                hcmd.upd     = 1'b1;
                hcmd.dec_en  = (pix_rdata_reg != '0);
                hcmd.dec_idx = pix_rdata_reg;
                hcmd.inc_idx = nv;
            end
            pdia_pkg::ST_RD_DAT:
            begin
                num_x       = CW'(stretch_num);
                den_x       = QW'(eff_thr);
                div_start_x = auto_reg && pix_rdata_reg != '0 && pix_rdata_reg <= eff_thr;
            end
            default:
                in_ready = 1'b0;
        endcase
    end

    // datapath registers
    always_comb
    begin
        clr_cnt_next    = clr_cnt_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        addr_next       = addr_reg;
        res_status_next = res_status_reg;
        res_pix_next    = res_pix_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_status_next = out_status_reg;
        out_pix_next    = out_pix_reg;
        out_thr_next    = out_thr_reg;
        case (state_reg)
            pdia_pkg::ST_CLEAR:
                clr_cnt_next = clr_cnt_reg + 1'b1;
            pdia_pkg::ST_IDLE:
            begin
                x_next          = x_coord;
                y_next          = y_coord;
                addr_next       = addr_calc;
                res_status_next = (mode == pdia_pkg::MODE_READ) && !rd_in_grid;
                res_pix_next    = '0;
            end
            pdia_pkg::ST_DIV:
            begin
                addr_next       = addr_calc;
                res_status_next = !(x_ok && y_ok);
            end
            pdia_pkg::ST_RD_DAT:
            begin
                if (auto_reg && pix_rdata_reg > eff_thr)
                    res_pix_next = eff_max;
                else
                    res_pix_next = pix_rdata_reg;
            end
            pdia_pkg::ST_SDIV:
                res_pix_next = quo_x[IW-1:0];
            pdia_pkg::ST_FIN:
            begin
                if (res_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_pix_next    = res_pix_reg;
                    out_thr_next    = hist_thr;
                end
            end
            default:
                clr_cnt_next = clr_cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pdia_pkg::ST_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg          <= x_next;
        y_reg          <= y_next;
        addr_reg       <= addr_next;
        res_status_reg <= res_status_next;
        res_pix_reg    <= res_pix_next;
        out_status_reg <= out_status_next;
        out_pix_reg    <= out_pix_next;
        out_thr_reg    <= out_thr_next;
    end

    always_ff @(posedge clk)
    begin
        if (pix_we)
            pix_mem[pix_waddr] <= pix_wdata;
        if (pix_re)
            pix_rdata_reg <= pix_mem[addr_reg];
    end

    pdia_div u_div_x (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start_x),
        .numer (num_x),
        .denom (den_x),
        .done  (div_done_x),
        .quot  (quo_x)
    );

    pdia_div u_div_y (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start_y),
        .numer (abs_y),
        .denom (eff_cpp),
        .done  (div_done_y),
        .quot  (quo_y)
    );

    pdia_hist u_hist (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (hcmd),
        .eff_max   (eff_max),
        .quantile  (q_reg),
        .done      (hist_done),
        .threshold (hist_thr)
    );

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign pixel_value = out_pix_reg;
    assign threshold   = out_thr_reg;

endmodule

// File: rtl/core/pdia_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdia_checker
// port-level checks on the point density image accumulator
// ----------------------------------------------------------------------------
`include "point_density_image_accumulator_assert.svh"

module pdia_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic                              status,
    input logic [pdia_pkg::INT_W-1:0]        pixel_value,
    input logic [pdia_pkg::INT_W-1:0]        threshold
);

    // a waiting result holds
    `PDIA_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(pixel_value) && $stable(status) && $stable(threshold), "result changed while stalled")
    // a dropped item carries no pixel
    `PDIA_ASSERT_NOW(a_drop_zero, out_valid && status, pixel_value == '0, "dropped transaction has pixel data")
    // threshold never reaches zero
    `PDIA_ASSERT_NOW(a_thr_nonzero, out_valid, threshold != '0, "zero threshold on output")
    // one transaction at a time
    `PDIA_ASSERT_NXT(a_one_item, in_valid && in_ready, !in_ready, "transaction taken while busy")

endmodule

bind point_density_image_accumulator pdia_checker u_pdia_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .pixel_value (pixel_value),
    .threshold   (threshold)
);
